// File: rtl/core/lpa_pkg.sv
// Shared types, codes and colour tables for the LED pattern animator.
// No dependencies; used by lpa_div, lpa_blend and led_pattern_animator.
`default_nettype none

package lpa_pkg;

    // request kinds on the input stream (carried in s_tuser)
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_SET  = 2'd1;
    localparam logic [1:0] FUNC_NEXT = 2'd2;

    // pattern codes
    localparam logic [1:0] PAT_RAINBOW   = 2'd0;
    localparam logic [1:0] PAT_CYAN_PINK = 2'd1;
    localparam logic [1:0] PAT_ORNG_BLUE = 2'd2;
    localparam logic [1:0] PAT_OFF       = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SPEED  = 2'd0;
    localparam logic [1:0] CFG_FADE   = 2'd1;
    localparam logic [1:0] CFG_BRIGHT = 2'd2;

    // reset values
    localparam logic [15:0] SPEED_RST  = 16'd100;
    localparam logic [7:0]  FADE_RST   = 8'd64;
    localparam logic [7:0]  BRIGHT_RST = 8'd32;
    localparam logic [7:0]  HUE_LAST   = 8'd191;
    localparam logic [7:0]  HUE_STEP   = 8'd45;
    localparam int unsigned SLOW_FACTOR = 100;
    localparam logic [15:0] FAST_RELOAD = 16'd10;

    localparam int unsigned NUM_CH = 6;   // three channels per colour, two colours

    // request from the top level to the blend sequencer
    typedef struct packed {
        logic       go;
        logic [7:0] step;
        logic       orange;   // second colour: 0 pink, 1 orange
    } blend_req_t;

    // one fade advance
    typedef struct packed {
        logic [7:0] step;
        logic       falling;
        logic       turn;
    } fade_t;

    // start colour of channel idx: 0..2 cyan (r,g,b), 3..5 pink or orange
    function automatic logic [7:0] fade_start(input logic orange, input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'd35;
            3'd1:    v = 8'd181;
            3'd2:    v = 8'd232;
            3'd3:    v = orange ? 8'd26 : 8'd55;
            3'd4:    v = orange ? 8'd5  : 8'd0;
            3'd5:    v = orange ? 8'd0  : 8'd55;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // end colour of channel idx
    function automatic logic [7:0] fade_end(input logic orange, input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'd4;
            3'd1:    v = 8'd20;
            3'd2:    v = 8'd26;
            3'd3:    v = 8'd255;
            3'd4:    v = orange ? 8'd50 : 8'd0;
            3'd5:    v = orange ? 8'd0  : 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/led_pattern_animator.sv
// LED pattern animator for four LEDs: rainbow, cyan/pink fade, orange/blue fade
// with random pause, and off. Every input request is taken whenever the block
// is idle. Set and next requests, and ticks that only count the prescaler down
// or pause the orange/blue fade, give no result. Off ticks and rainbow steps
// write their result straight into the result register, which passes it to the
// output register once that is free. A fade step runs the six colour channels
// one after another through a single bit-serial divider (one quotient bit per
// cycle) and stages its result once the last channel is done. The result
// register is separate from the working state: a new request is taken while a
// result still waits on m_tvalid. Configuration writes are always ready and
// should be made only while the block is idle. Depends on lpa_pkg and lpa_blend.
`default_nettype none

module led_pattern_animator (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input requests
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // pattern_number[2:0], random_extra[13:3], zero pad
    input  wire logic [1:0]   s_tuser,   // func
    // results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // brightness[7:0], led0..led3 color, 24 bits each
    output logic              m_tuser,   // color_kind
    // configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    import lpa_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_BLEND   = 2'd1;
    localparam logic [1:0] ST_DELIVER = 2'd2;

    // configuration
    logic [15:0] speed_reg;
    logic [7:0]  fade_reg;
    logic [7:0]  bright_reg;

    // animation state
    logic [1:0]  state_reg, state_next;
    logic [15:0] presc_reg, presc_next;
    logic [1:0]  pat_reg, pat_next;
    logic [7:0]  hue_reg [4];
    logic [7:0]  hue_next [4];
    logic [7:0]  cp_step_reg, cp_step_next;
    logic        cp_fall_reg, cp_fall_next;
    logic [7:0]  ob_step_reg, ob_step_next;
    logic        ob_fall_reg, ob_fall_next;

    // staged result and output register
    logic         res_kind_reg, res_kind_next;
    logic [103:0] res_data_reg, res_data_next;
    logic         m_valid_reg, m_valid_next;
    logic         m_kind_reg, m_kind_next;
    logic [103:0] m_data_reg, m_data_next;

    blend_req_t   breq;
    logic         blend_done;
    logic [23:0]  color_a;
    logic [23:0]  color_b;

    logic [2:0]   pnum;
    logic [10:0]  extra;
    fade_t        cp_adv;
    fade_t        ob_adv;

    function automatic fade_t fade_adv(input logic [7:0] step, input logic falling,
                                       input logic [7:0] fs);
        fade_t r;
        r.step    = step;
        r.falling = falling;
        r.turn    = 1'b0;
        if (falling) begin
            if (step != 8'd0) r.step = step - 8'd1;
            else begin
                r.falling = 1'b0;
                r.turn    = 1'b1;
            end
        end else begin
            if (step < fs) r.step = step + 8'd1;
            else begin
                r.falling = 1'b1;
                r.turn    = 1'b1;
            end
        end
        return r;
    endfunction

    assign pnum   = s_tdata[2:0];
    assign extra  = s_tdata[13:3];
    assign cp_adv = fade_adv(cp_step_reg, cp_fall_reg, fade_reg);
    assign ob_adv = fade_adv(ob_step_reg, ob_fall_reg, fade_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    lpa_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (breq),
        .fade_steps (fade_reg),
        .done       (blend_done),
        .color_a    (color_a),
        .color_b    (color_b)
    );

    always_comb begin
        state_next    = state_reg;
        presc_next    = presc_reg;
        pat_next      = pat_reg;
        for (int i = 0; i < 4; i++) hue_next[i] = hue_reg[i];
        cp_step_next  = cp_step_reg;
        cp_fall_next  = cp_fall_reg;
        ob_step_next  = ob_step_reg;
        ob_fall_next  = ob_fall_reg;
        res_kind_next = res_kind_reg;
        res_data_next = res_data_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        m_kind_next   = m_kind_reg;
        m_data_next   = m_data_reg;
        breq          = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        FUNC_SET: begin
                            if (!pnum[2]) pat_next = pnum[1:0];
                        end
                        FUNC_NEXT: begin
                            if (pat_reg == PAT_OFF) begin
                                pat_next   = PAT_RAINBOW;
                                presc_next = 16'd0;
                            end else begin
                                pat_next = pat_reg + 2'd1;
                            end
                        end
                        FUNC_TICK: begin
                            if (pat_reg == PAT_OFF) begin
                                res_kind_next = 1'b0;
                                res_data_next = '0;
                                state_next    = ST_DELIVER;
                            end else if (presc_reg != 16'd0) begin
                                presc_next = presc_reg - 16'd1;
                            end else if (pat_reg == PAT_RAINBOW) begin
                                for (int i = 0; i < 4; i++) begin
                                    hue_next[i] = (hue_reg[i] >= HUE_LAST) ? 8'd0
                                                                          : hue_reg[i] + 8'd1;
                                end
                                res_kind_next = 1'b1;
                                res_data_next = {16'd0, hue_next[3], 16'd0, hue_next[2],
                                                 16'd0, hue_next[1], 16'd0, hue_next[0],
                                                 bright_reg};
                                presc_next    = speed_reg;
                                state_next    = ST_DELIVER;
                            end else if (pat_reg == PAT_CYAN_PINK) begin
                                cp_step_next = cp_adv.step;
                                cp_fall_next = cp_adv.falling;
                                presc_next   = speed_reg;
                                breq.go      = 1'b1;
                                breq.step    = cp_adv.step;
                                breq.orange  = 1'b0;
                                state_next   = ST_BLEND;
                            end else begin
                                ob_step_next = ob_adv.step;
                                ob_fall_next = ob_adv.falling;
                                if (ob_adv.turn) begin
                                    // long pause, no result
                                    presc_next = 16'(32'(speed_reg) * 32'(SLOW_FACTOR)
                                                     + 32'(extra));
                                end else begin
                                    presc_next  = FAST_RELOAD;
                                    breq.go     = 1'b1;
                                    breq.step   = ob_adv.step;
                                    breq.orange = 1'b1;
                                    state_next  = ST_BLEND;
                                end
                            end
                        end
                        default: ;   // unused request kind
                    endcase
                end
            end
            ST_BLEND: begin
                if (blend_done) begin
                    res_kind_next = 1'b0;
                    res_data_next = {color_b, color_b, color_a, color_a, 8'd0};
                    state_next    = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = res_kind_reg;
                    m_data_next  = res_data_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg   <= SPEED_RST;
            fade_reg    <= FADE_RST;
            bright_reg  <= BRIGHT_RST;
            state_reg   <= ST_IDLE;
            presc_reg   <= SPEED_RST;
            pat_reg     <= PAT_RAINBOW;
            for (int i = 0; i < 4; i++) hue_reg[i] <= 8'(i) * HUE_STEP;
            cp_step_reg <= 8'd0;
            cp_fall_reg <= 1'b0;
            ob_step_reg <= 8'd0;
            ob_fall_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SPEED:  speed_reg  <= cfg_data;
                    CFG_FADE:   fade_reg   <= cfg_data[7:0];
                    CFG_BRIGHT: bright_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            state_reg   <= state_next;
            presc_reg   <= presc_next;
            pat_reg     <= pat_next;
            for (int i = 0; i < 4; i++) hue_reg[i] <= hue_next[i];
            cp_step_reg <= cp_step_next;
            cp_fall_reg <= cp_fall_next;
            ob_step_reg <= ob_step_next;
            ob_fall_reg <= ob_fall_next;
            m_valid_reg <= m_valid_next;
        end
        res_kind_reg <= res_kind_next;
        res_data_reg <= res_data_next;
        m_kind_reg   <= m_kind_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = m_data_reg;

    // blend results only arrive while a fade step is in flight
    a_blend_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        blend_done |-> state_reg == ST_BLEND)
        else $error("blend finished outside a fade step");

    // a staged result waits while the output register is held
    a_deliver_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DELIVER) && m_valid_reg && !m_tready |=> state_reg == ST_DELIVER)
        else $error("result staged over a held output");

    // hues never leave their range
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (hue_reg[0] <= HUE_LAST) && (hue_reg[1] <= HUE_LAST) &&
        (hue_reg[2] <= HUE_LAST) && (hue_reg[3] <= HUE_LAST))
        else $error("hue out of range");

endmodule

`default_nettype wire

// File: rtl/core/lpa_div.sv
// One colour channel: start + trunc(step * (end - start) / fade_steps), low 8 bits.
// Bit-serial restoring divider, one quotient bit per cycle. Uses lpa_pkg.
`default_nettype none

module lpa_div (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       go,
    input  wire logic [7:0] step,
    input  wire logic [7:0] ch_start,
    input  wire logic [7:0] ch_end,
    input  wire logic [7:0] fade_steps,
    output logic            done,
    output logic [7:0]      ch
);
    import lpa_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] dvd_reg, dvd_next;     // dividend in, quotient out
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  start_reg, start_next;
    logic [7:0]  dsr_reg, dsr_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;

    logic [8:0]  diff;
    logic [7:0]  mag;
    logic [8:0]  rem_sh;
    logic        fits;
    logic [7:0]  q_lo;

    assign diff   = {1'b0, ch_end} - {1'b0, ch_start};
    assign mag    = diff[8] ? 8'(9'd0 - diff) : diff[7:0];
    assign rem_sh = {rem_reg, dvd_reg[15]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        start_next = start_reg;
        dsr_next   = dsr_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        if (go) begin
            busy_next  = 1'b1;
            cnt_next   = 4'd15;
            dvd_next   = 16'(step) * 16'(mag);
            rem_next   = 8'd0;
            start_next = ch_start;
            dsr_next   = fade_steps;
            neg_next   = diff[8];
            zero_next  = (fade_steps == 8'd0);
        end else if (busy_reg) begin
            rem_next = fits ? 8'(rem_sh - {1'b0, dsr_reg}) : rem_sh[7:0];
            dvd_next = {dvd_reg[14:0], fits};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg   <= cnt_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        start_reg <= start_next;
        dsr_reg   <= dsr_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
    end

    // only the low byte of the quotient reaches the result
    assign q_lo = zero_reg ? 8'd0 : (neg_reg ? 8'(8'd0 - dvd_reg[7:0]) : dvd_reg[7:0]);
    assign ch   = start_reg + q_lo;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/lpa_blend.sv
// Sequences the six fade channels through one lpa_div and packs two RGB colours.
// Depends on lpa_pkg and lpa_div.
`default_nettype none

module lpa_blend (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lpa_pkg::blend_req_t req,
    input  wire logic [7:0]          fade_steps,
    output logic                     done,
    output logic [23:0]              color_a,
    output logic [23:0]              color_b
);
    import lpa_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic        kick_reg, kick_next;
    logic        done_reg, done_next;
    logic [7:0]  step_reg, step_next;
    logic        orange_reg, orange_next;
    logic [47:0] acc_reg, acc_next;   // channels shift in a byte at a time

    logic        div_done;
    logic [7:0]  div_ch;

    lpa_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .go         (kick_reg),
        .step       (step_reg),
        .ch_start   (fade_start(orange_reg, idx_reg)),
        .ch_end     (fade_end(orange_reg, idx_reg)),
        .fade_steps (fade_steps),
        .done       (div_done),
        .ch         (div_ch)
    );

    always_comb begin
        idx_next    = idx_reg;
        kick_next   = 1'b0;
        done_next   = 1'b0;
        step_next   = step_reg;
        orange_next = orange_reg;
        acc_next    = acc_reg;
        if (req.go) begin
            idx_next    = 3'd0;
            kick_next   = 1'b1;
            step_next   = req.step;
            orange_next = req.orange;
        end else if (div_done) begin
            acc_next = {acc_reg[39:0], div_ch};
            if (idx_reg == 3'(NUM_CH - 1)) begin
                done_next = 1'b1;
            end else begin
                idx_next  = idx_reg + 3'd1;
                kick_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kick_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            kick_reg <= kick_next;
            done_reg <= done_next;
        end
        idx_reg    <= idx_next;
        step_reg   <= step_next;
        orange_reg <= orange_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign color_a = acc_reg[47:24];
    assign color_b = acc_reg[23:0];

endmodule

`default_nettype wire

// File: dv/led_pattern_animator_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for led_pattern_animator: random tick/set/next requests with
// handshake gaps, frames predicted in-bench and scoreboarded on m_tdata/m_tuser.
// Depends on lpa_pkg (request, pattern and register codes) and the RTL top.

module led_pattern_animator_tb;
    import lpa_pkg::*;

    localparam logic [1:0]  FUNC_NOP    = 2'd3;      // unused request kind, must do nothing
    localparam logic [7:0]  HUE_WRAP    = 8'd191;    // last hue before wrapping to 0
    localparam int unsigned PAUSE_MULT  = 100;       // orange/blue turnaround pause factor
    localparam logic [15:0] STEP_RELOAD = 16'd10;    // orange/blue reload between steps

    // fade end points, red in 23:16, green 15:8, blue 7:0
    localparam logic [23:0] CYAN_FROM = 24'h23B5E8;
    localparam logic [23:0] CYAN_TO   = 24'h04141A;
    localparam logic [23:0] PINK_FROM = 24'h370037;
    localparam logic [23:0] PINK_TO   = 24'hFF00FF;
    localparam logic [23:0] ORNG_FROM = 24'h1A0500;
    localparam logic [23:0] ORNG_TO   = 24'hFF3200;

    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  pnum;
        logic [10:0] extra;
    } req_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  bright;
        logic [23:0] led0;
        logic [23:0] led1;
        logic [23:0] led2;
        logic [23:0] led3;
    } frame_t;

    typedef struct packed {
        logic [7:0] pos;
        logic       down;
        logic       turn;
    } ramp_t;

    // DUT signals, all inputs known from time zero
    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_tvalid  = 1'b0;
    wire           s_tready;
    logic [15:0]   s_tdata   = '0;   // pattern_number[2:0], random_extra[13:3], zero pad
    logic [1:0]    s_tuser   = FUNC_TICK;   // func
    wire           m_tvalid;
    logic          m_tready  = 1'b0;
    wire  [103:0]  m_tdata;          // brightness[7:0], led0..led3 color, 24 bits each
    wire           m_tuser;          // color_kind
    logic          cfg_valid = 1'b0;
    wire           cfg_ready;
    logic [1:0]    cfg_index = CFG_SPEED;
    logic [15:0]   cfg_data  = '0;

    // pending requests and expected frames
    req_t   req_q[$];
    frame_t frame_q[$];

    // predicted block state, starting from reset values
    logic [15:0] speed_cfg   = 16'd100;
    logic [7:0]  fade_cfg    = 8'd64;
    logic [7:0]  bright_cfg  = 8'd32;
    logic [15:0] tick_count  = 16'd100;
    logic [1:0]  cur_pattern = PAT_RAINBOW;
    logic [7:0]  hue [4]     = '{8'd0, 8'd45, 8'd90, 8'd135};
    ramp_t       cp_ramp     = '0;
    ramp_t       ob_ramp     = '0;

    // bench bookkeeping
    logic   bursts_on    = 1'b1;
    logic   req_taken    = 1'b0;
    int     send_gap     = 0;
    int     sink_hold    = 0;
    int     quiet_cycles = 0;
    int     fail_count   = 0;
    req_t   next_req;
    req_t   seen_req;
    frame_t got_frame;
    frame_t want_frame;

    led_pattern_animator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------

    // One ping-pong move: count toward the far end, turn around without moving at
    // either end. A rising ramp already past fade_cfg (register lowered) turns too.
    function automatic ramp_t ramp_next(input ramp_t r);
        ramp_t n;
        n = r;
        n.turn = 1'b0;
        if (r.down) begin
            if (r.pos != 8'd0) begin
                n.pos = r.pos - 8'd1;
            end else begin
                n.down = 1'b0;
                n.turn = 1'b1;
            end
        end else if (r.pos < fade_cfg) begin
            n.pos = r.pos + 8'd1;
        end else begin
            n.down = 1'b1;
            n.turn = 1'b1;
        end
        return n;
    endfunction

    // Per channel: from + pos*(to-from)/fade_cfg, signed and truncating toward zero,
    // low 8 bits kept. Zero fade steps give the start colour.
    function automatic logic [23:0] mix(input logic [23:0] from_c, input logic [23:0] to_c,
                                        input logic [7:0] pos);
        int a, b, q, t, n;
        logic [23:0] c;
        c = '0;
        t = int'(pos);
        n = int'(fade_cfg);
        for (int k = 0; k < 3; k++) begin
            a = int'(from_c[k*8 +: 8]);
            b = int'(to_c[k*8 +: 8]);
            q = (n == 0) ? 0 : (t * (b - a)) / n;
            c[k*8 +: 8] = 8'(a + q);
        end
        return c;
    endfunction

    // Apply one accepted request to the predicted state; queue the frame it causes.
    task automatic animate(input req_t r);
        frame_t f;
        logic [31:0] pause;
        f = '0;
        case (r.func)
            FUNC_SET: begin
                if (r.pnum < 3'd4)
                    cur_pattern = r.pnum[1:0];
            end
            FUNC_NEXT: begin
                // wrapping back to rainbow also clears the prescaler
                if (cur_pattern == PAT_OFF) begin
                    cur_pattern = PAT_RAINBOW;
                    tick_count  = '0;
                end else begin
                    cur_pattern = cur_pattern + 2'd1;
                end
            end
            FUNC_TICK: begin
                if (cur_pattern == PAT_OFF) begin
                    frame_q.push_back(f);   // dark frame on every tick, prescaler untouched
                end else if (tick_count != 16'd0) begin
                    tick_count = tick_count - 16'd1;
                end else begin
                    case (cur_pattern)
                        PAT_RAINBOW: begin
                            for (int i = 0; i < 4; i++)
                                hue[i] = (hue[i] >= HUE_WRAP) ? 8'd0 : hue[i] + 8'd1;
                            f.kind   = 1'b1;
                            f.bright = bright_cfg;
                            f.led0   = {16'h0, hue[0]};
                            f.led1   = {16'h0, hue[1]};
                            f.led2   = {16'h0, hue[2]};
                            f.led3   = {16'h0, hue[3]};
                            tick_count = speed_cfg;
                            frame_q.push_back(f);
                        end
                        PAT_CYAN_PINK: begin
                            // shows turnaround steps as well
                            cp_ramp = ramp_next(cp_ramp);
                            f.led0  = mix(CYAN_FROM, CYAN_TO, cp_ramp.pos);
                            f.led1  = f.led0;
                            f.led2  = mix(PINK_FROM, PINK_TO, cp_ramp.pos);
                            f.led3  = f.led2;
                            tick_count = speed_cfg;
                            frame_q.push_back(f);
                        end
                        default: begin
                            ob_ramp = ramp_next(ob_ramp);
                            if (ob_ramp.turn) begin
                                // long random pause, no frame
                                pause      = 32'(speed_cfg) * 32'(PAUSE_MULT)
                                             + 32'(r.extra);
                                tick_count = pause[15:0];
                            end else begin
                                f.led0 = mix(CYAN_FROM, CYAN_TO, ob_ramp.pos);
                                f.led1 = f.led0;
                                f.led2 = mix(ORNG_FROM, ORNG_TO, ob_ramp.pos);
                                f.led3 = f.led2;
                                tick_count = STEP_RELOAD;
                                frame_q.push_back(f);
                            end
                        end
                    endcase
                end
            end
            default: ;   // unused kind
        endcase
    endtask

    task automatic cmp_field(input string what, input logic [23:0] want_v,
                             input logic [23:0] got_v);
        if (want_v !== got_v) begin
            fail_count++;
            $display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: launches at the falling edge, holds until taken
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !req_taken)) begin
            if (send_gap != 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (req_q.size() != 0) begin
                next_req = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_req.func;
                s_tdata  <= {2'b00, next_req.extra, next_req.pnum};
                if (bursts_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 10);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: random stall bursts on m_tready
    always @(negedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (bursts_on && $urandom_range(0, 9) == 0)
                sink_hold = $urandom_range(1, 10);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            req_taken <= s_tvalid && s_tready;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SPEED:  speed_cfg  = cfg_data;
                    CFG_FADE:   fade_cfg   = cfg_data[7:0];
                    CFG_BRIGHT: bright_cfg = cfg_data[7:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                seen_req = {s_tuser, s_tdata[2:0], s_tdata[13:3]};
                animate(seen_req);
            end

            if (m_tvalid && m_tready) begin
                got_frame = {m_tuser, m_tdata[7:0], m_tdata[31:8], m_tdata[55:32],
                             m_tdata[79:56], m_tdata[103:80]};
                if (frame_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: frame expected none, got %h", $time, got_frame);
                end else begin
                    want_frame = frame_q.pop_front();
                    cmp_field("color_kind", 24'(want_frame.kind), 24'(got_frame.kind));
                    cmp_field("brightness", 24'(want_frame.bright), 24'(got_frame.bright));
                    cmp_field("led0_color", want_frame.led0, got_frame.led0);
                    cmp_field("led1_color", want_frame.led1, got_frame.led1);
                    cmp_field("led2_color", want_frame.led2, got_frame.led2);
                    cmp_field("led3_color", want_frame.led3, got_frame.led3);
                end
            end

            // watchdog: no handshake of any kind for too long
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_req(input logic [1:0] func, input logic [2:0] pnum,
                             input logic [10:0] extra);
        req_t r;
        r = {func, pnum, extra};
        req_q.push_back(r);
    endtask

    function automatic req_t random_req();
        req_t r;
        int roll;
        roll = $urandom_range(0, 99);
        r.func = (roll < 85) ? FUNC_TICK : (roll < 93) ? FUNC_SET :
                 (roll < 98) ? FUNC_NEXT : FUNC_NOP;
        r.pnum = 3'($urandom_range(0, 7));
        // mostly short pauses so orange/blue keeps stepping; full width now and then
        r.extra = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                              : 11'($urandom_range(0, 15));
        return r;
    endfunction

    // Wait until every request is taken and every frame is in, then give silent
    // requests (prescale counts, turnaround pauses) time to finish inside the block.
    task automatic settle();
        while (req_q.size() != 0 || s_tvalid || frame_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // New register setting on an idle block, then a batch of random requests.
    // Upper data bits of the 8-bit registers are noise the block must drop.
    task automatic run_phase(input logic [15:0] speed, input logic [7:0] fade,
                             input logic [7:0] bright, input int n, input logic bursts);
        settle();
        bursts_on = bursts;
        write_reg(CFG_SPEED, speed);
        write_reg(CFG_FADE, {8'($urandom), fade});
        write_reg(CFG_BRIGHT, {8'($urandom), bright});
        repeat (n) req_q.push_back(random_req());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed requests on reset register values
        queue_req(FUNC_TICK, 3'd7, 11'h7FF);   // prescaler counts, widest fields
        queue_req(FUNC_SET,  3'd7, 11'h000);   // out-of-range set is ignored
        queue_req(FUNC_NOP,  3'd5, 11'h555);   // unused kind does nothing
        queue_req(FUNC_SET,  3'd3, 11'h2AA);   // off
        queue_req(FUNC_TICK, 3'd0, 11'h000);   // dark frame
        queue_req(FUNC_NEXT, 3'd0, 11'h000);   // wrap to rainbow, prescaler cleared
        queue_req(FUNC_TICK, 3'd0, 11'h000);   // first rainbow step
        queue_req(FUNC_SET,  3'd3, 11'h000);
        queue_req(FUNC_NEXT, 3'd0, 11'h000);
        queue_req(FUNC_SET,  3'd1, 11'h000);
        queue_req(FUNC_TICK, 3'd0, 11'h000);   // first cyan/pink step
        queue_req(FUNC_SET,  3'd3, 11'h000);
        queue_req(FUNC_NEXT, 3'd0, 11'h000);
        queue_req(FUNC_SET,  3'd2, 11'h000);
        queue_req(FUNC_TICK, 3'd4, 11'h400);   // first orange/blue step
        queue_req(FUNC_SET,  3'd0, 11'h000);
        queue_req(FUNC_TICK, 3'd0, 11'h000);
        queue_req(FUNC_NEXT, 3'd0, 11'h000);   // plain next, no wrap
        queue_req(FUNC_NEXT, 3'd0, 11'h000);
        queue_req(FUNC_NEXT, 3'd0, 11'h000);
        queue_req(FUNC_TICK, 3'd0, 11'h000);   // off again

        run_phase(16'd0,    8'd1,   8'd0,   160, 1'b1);   // fastest, shortest non-zero fade
        run_phase(16'd0,    8'd255, 8'd255, 200, 1'b1);   // longest fade
        run_phase(16'd1,    8'd4,   8'd32,  150, 1'b1);   // ramps now past the top
        run_phase(16'hFFFF, 8'd0,   8'd128, 30,  1'b1);   // slowest prescale, zero steps
        run_phase(16'd0,    8'd0,   8'($urandom), 120, 1'b1);
        repeat (4)
            run_phase(16'($urandom_range(0, 3)), 8'($urandom_range(1, 16)),
                      8'($urandom), 160, $urandom_range(0, 3) != 0);
        // closing stretch without idling on either side
        run_phase(16'd2,    8'd3,   8'($urandom), 120, 1'b0);
        run_phase(16'd0,    8'd64,  8'd32,  120, 1'b0);
        settle();

        if (fail_count == 0 && frame_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/lpa_pkg.sv
rtl/core/lpa_div.sv
rtl/core/lpa_blend.sv
rtl/core/led_pattern_animator.sv
dv/led_pattern_animator_tb.sv
